FILE: src/krpt_pkg.sv
package krpt_pkg;

  localparam int ENTRIES_DEF  = 32;
  localparam int KEY_BITS_DEF = 64;
  localparam int KEY_W        = 64;
  localparam int ROOT_W       = 32;
  localparam int MAX_RESULTS  = 32;
  localparam int RES_CNT_W    = $clog2(MAX_RESULTS);

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_DELETE = 3'd1;
  localparam logic [2:0] OP_LOOKUP = 3'd2;
  localparam logic [2:0] OP_RANGE  = 3'd3;
  localparam logic [2:0] OP_BOUNDS = 3'd4;
  localparam logic [2:0] OP_UPDATE = 3'd5;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EXISTS    = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_LAST      = 3'd3,
    ST_UNORDERED = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  typedef struct packed {
    logic [2:0]        operation;
    logic [KEY_W-1:0]  key;
    logic [KEY_W-1:0]  key_high;
    logic [ROOT_W-1:0] root;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [ROOT_W-1:0] root_a;
    logic [ROOT_W-1:0] root_b;
    logic [KEY_W-1:0]  key_a;
    logic [KEY_W-1:0]  key_b;
    logic              upper_is_infinite;
    logic              last;
  } rsp_t;

endpackage

FILE: src/key_range_partition_table_core.sv
// key range partition table: sorted start keys with root page ids, floor lookup
// request channel: a request is taken at a rising edge with start high and busy
//   low; busy stays high until the request is done with the table, and a delete
//   keeps it high while it closes the gap behind its result
// result channel: each result sits on result for exactly one cycle with done
//   high; result.last marks the final result of a request; the receiver cannot
//   stall, so results simply stream out
// every request first scans the table, one entry per cycle through the
//   registered read port of the key/root memories, then enters the decide state
// lookup, bounds and update finish there
// insert then shifts the higher entries up, a read and a write state per moved
//   entry, and then writes the new entry in the place state
// delete shifts the entries above the erased one down, a read and a write state each
// range query emits each result from a read state and an output state, at most 32 results
// unknown operation codes are taken and dropped with no result
// the single memory read port makes the scan and the shifts go one entry at a
//   time; one request is handled at a time
// reset empties the table (entry count to zero); memory contents are left as
//   they are and are never read before being written
module key_range_partition_table_core #(
  parameter int ENTRIES  = krpt_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = krpt_pkg::KEY_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  krpt_pkg::req_t request,
  output logic           done,
  output krpt_pkg::rsp_t result
);

  import krpt_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);

  // one-hot sequencer
  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_SCAN   = 10'b0000000010,
    S_DECIDE = 10'b0000000100,
    S_SH_RD  = 10'b0000001000,
    S_SH_WR  = 10'b0000010000,
    S_PLACE  = 10'b0000100000,
    S_DN_RD  = 10'b0001000000,
    S_DN_WR  = 10'b0010000000,
    S_RG_RD  = 10'b0100000000,
    S_RG_OUT = 10'b1000000000
  } state_t;

  state_t state;

  // table storage
  logic [KEY_BITS-1:0] keys_mem  [ENTRIES];
  logic [ROOT_W-1:0]   roots_mem [ENTRIES];
  logic [KEY_BITS-1:0] rd_key;
  logic [ROOT_W-1:0]   rd_root;
  logic [IDX_W-1:0]    rd_addr;
  logic [CNT_W-1:0]    rd_sum;

  logic                wr_key_en;
  logic                wr_root_en;
  logic [IDX_W-1:0]    wr_addr;
  logic [KEY_BITS-1:0] wr_key;
  logic [ROOT_W-1:0]   wr_root;

  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    ptr;

  // latched request
  logic [2:0]          q_op;
  logic [KEY_BITS-1:0] q_key;
  logic [KEY_BITS-1:0] q_high;
  logic [ROOT_W-1:0]   q_root;

  // scan pipeline: read issued last cycle is valid now
  logic                pv;
  logic [IDX_W-1:0]    pidx;

  // scan trackers
  logic                f_found;
  logic [IDX_W-1:0]    f_idx;
  logic [KEY_BITS-1:0] f_key;
  logic [ROOT_W-1:0]   f_root;
  logic [KEY_BITS-1:0] p_key;
  logic [ROOT_W-1:0]   p_root;
  logic [KEY_BITS-1:0] prev_key;
  logic [ROOT_W-1:0]   prev_root;
  logic [KEY_BITS-1:0] n1_key;
  logic [ROOT_W-1:0]   n1_root;
  logic                e_found;
  logic [IDX_W-1:0]    e_idx;
  logic                g_found;
  logic [IDX_W-1:0]    g_idx;
  logic                m_found;
  logic                m_has_next;
  logic [KEY_BITS-1:0] m_key;
  logic [ROOT_W-1:0]   m_root;
  logic [KEY_BITS-1:0] m_nkey;

  logic [CNT_W-1:0]     ins_pos;
  logic [RES_CNT_W-1:0] n_res;

  // helper sums for delete
  logic [CNT_W:0]      f_pos;
  logic [CNT_W-1:0]    gone_idx;
  logic [CNT_W:0]      gone_plus1;
  logic [CNT_W:0]      ptr_plus2;
  logic                range_last;

  // result of the current cycle, registered by the sequencer
  logic                done_next;
  rsp_t                result_next;

  assign busy = (state != S_IDLE);

  assign f_pos      = f_found ? ((CNT_W + 1)'(f_idx) + 1'b1) : '0;
  assign gone_idx   = (f_idx != '0) ? CNT_W'(f_idx) : CNT_W'(1);
  assign gone_plus1 = (CNT_W + 1)'(gone_idx) + 1'b1;
  assign ptr_plus2  = (CNT_W + 1)'(ptr) + 2'd2;
  assign range_last = (ptr == CNT_W'(g_idx)) || (n_res == RES_CNT_W'(MAX_RESULTS - 1));

  // read address
  always_comb begin
    unique case (state)
      S_SH_RD: rd_sum = ptr - 1'b1;
      S_DN_RD: rd_sum = ptr + 1'b1;
      default: rd_sum = ptr;
    endcase
    rd_addr = rd_sum[IDX_W-1:0];
  end

  // write port
  always_comb begin
    wr_key_en  = 1'b0;
    wr_root_en = 1'b0;
    wr_addr    = ptr[IDX_W-1:0];
    wr_key     = rd_key;
    wr_root    = rd_root;
    unique case (state)
      S_SH_WR, S_DN_WR: begin
        wr_key_en  = 1'b1;
        wr_root_en = 1'b1;
      end
      S_PLACE: begin
        wr_key_en  = 1'b1;
        wr_root_en = 1'b1;
        wr_addr    = ins_pos[IDX_W-1:0];
        wr_key     = q_key;
        wr_root    = q_root;
      end
      S_DECIDE: begin
        // root update on an exact key
        if (q_op == OP_UPDATE && e_found) begin
          wr_root_en = 1'b1;
          wr_addr    = e_idx;
          wr_root    = q_root;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_key_en) begin
      keys_mem[wr_addr] <= wr_key;
    end
    if (wr_root_en) begin
      roots_mem[wr_addr] <= wr_root;
    end
    rd_key  <= keys_mem[rd_addr];
    rd_root <= roots_mem[rd_addr];
  end

  // result builder: decide cycle, placement and each range row
  always_comb begin
    done_next        = 1'b0;
    result_next      = '0;
    result_next.last = 1'b1;
    unique case (state)
      S_DECIDE: begin
        unique case (q_op)
          OP_INSERT: begin
            if (e_found) begin
              done_next          = 1'b1;
              result_next.status = ST_EXISTS;
            end else if (count == CNT_W'(ENTRIES)) begin
              done_next          = 1'b1;
              result_next.status = ST_FULL;
            end
          end
          OP_DELETE: begin
            done_next = 1'b1;
            if (!f_found) begin
              result_next.status = ST_NOT_FOUND;
            end else if (count <= CNT_W'(1)) begin
              result_next.status = ST_LAST;
            end else begin
              result_next.status = ST_OK;
              if (f_idx != '0) begin
                // floor entry merges into its lower neighbour
                result_next.root_a = p_root;
                result_next.key_a  = KEY_W'(p_key);
                result_next.root_b = f_root;
                result_next.key_b  = KEY_W'(f_key);
              end else begin
                // lowest entry absorbs its higher neighbour
                result_next.root_a = f_root;
                result_next.key_a  = KEY_W'(f_key);
                result_next.root_b = n1_root;
                result_next.key_b  = KEY_W'(n1_key);
              end
            end
          end
          OP_LOOKUP: begin
            done_next = 1'b1;
            if (f_found) begin
              result_next.status = ST_OK;
              result_next.root_a = f_root;
              result_next.key_a  = KEY_W'(f_key);
            end else begin
              result_next.status = ST_NOT_FOUND;
            end
          end
          OP_RANGE: begin
            if (q_high < q_key) begin
              done_next          = 1'b1;
              result_next.status = ST_UNORDERED;
            end else if (!f_found || !g_found) begin
              done_next          = 1'b1;
              result_next.status = ST_NOT_FOUND;
            end
          end
          OP_BOUNDS: begin
            done_next = 1'b1;
            if (m_found) begin
              result_next.status            = ST_OK;
              result_next.root_a            = m_root;
              result_next.key_a             = KEY_W'(m_key);
              result_next.key_b             = m_has_next ? KEY_W'(m_nkey) : '0;
              result_next.upper_is_infinite = !m_has_next;
            end else begin
              result_next.status = ST_NOT_FOUND;
            end
          end
          OP_UPDATE: begin
            done_next          = 1'b1;
            result_next.status = e_found ? ST_OK : ST_NOT_FOUND;
          end
          default: begin
          end
        endcase
      end
      S_PLACE: begin
        done_next          = 1'b1;
        result_next.status = ST_OK;
      end
      S_RG_OUT: begin
        done_next          = 1'b1;
        result_next.status = ST_OK;
        result_next.root_a = rd_root;
        result_next.key_a  = KEY_W'(rd_key);
        result_next.last   = range_last;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pv    <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= done_next;
      if (done_next) begin
        result <= result_next;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            q_op       <= request.operation;
            q_key      <= request.key[KEY_BITS-1:0];
            q_high     <= request.key_high[KEY_BITS-1:0];
            q_root     <= request.root;
            ptr        <= '0;
            pv         <= 1'b0;
            f_found    <= 1'b0;
            e_found    <= 1'b0;
            g_found    <= 1'b0;
            m_found    <= 1'b0;
            m_has_next <= 1'b0;
            // unknown codes are dropped here
            if (request.operation <= OP_UPDATE) begin
              state <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          // evaluate the entry read in the previous cycle
          if (pv) begin
            if (rd_key <= q_key) begin
              f_found <= 1'b1;
              f_idx   <= pidx;
              f_key   <= rd_key;
              f_root  <= rd_root;
              p_key   <= prev_key;
              p_root  <= prev_root;
            end
            if (rd_key == q_key) begin
              e_found <= 1'b1;
              e_idx   <= pidx;
            end
            if (rd_key <= q_high) begin
              g_found <= 1'b1;
              g_idx   <= pidx;
            end
            if (pidx == IDX_W'(1)) begin
              n1_key  <= rd_key;
              n1_root <= rd_root;
            end
            // highest entry owning the root, and the start key after it
            if (rd_root == q_root) begin
              m_found    <= 1'b1;
              m_has_next <= 1'b0;
              m_key      <= rd_key;
              m_root     <= rd_root;
            end else if (m_found && !m_has_next) begin
              m_has_next <= 1'b1;
              m_nkey     <= rd_key;
            end
            prev_key  <= rd_key;
            prev_root <= rd_root;
          end
          if (ptr < count) begin
            pv   <= 1'b1;
            pidx <= ptr[IDX_W-1:0];
            ptr  <= ptr + 1'b1;
          end else begin
            pv    <= 1'b0;
            state <= S_DECIDE;
          end
        end

        S_DECIDE: begin
          unique case (q_op)
            OP_INSERT: begin
              if (e_found || count == CNT_W'(ENTRIES)) begin
                state <= S_IDLE;
              end else begin
                ins_pos <= f_pos[CNT_W-1:0];
                ptr     <= count;
                if (count > f_pos[CNT_W-1:0]) begin
                  state <= S_SH_RD;
                end else begin
                  state <= S_PLACE;
                end
              end
            end
            OP_DELETE: begin
              if (f_found && count > CNT_W'(1)) begin
                ptr <= gone_idx;
                if (gone_plus1 < (CNT_W + 1)'(count)) begin
                  state <= S_DN_RD;
                end else begin
                  count <= count - 1'b1;
                  state <= S_IDLE;
                end
              end else begin
                state <= S_IDLE;
              end
            end
            OP_RANGE: begin
              if (q_high >= q_key && f_found && g_found) begin
                ptr   <= CNT_W'(f_idx);
                n_res <= '0;
                state <= S_RG_RD;
              end else begin
                state <= S_IDLE;
              end
            end
            default: begin
              // lookup, bounds and update end with the decide cycle
              state <= S_IDLE;
            end
          endcase
        end

        // insert: move entries up one place, top first
        S_SH_RD: begin
          state <= S_SH_WR;
        end
        S_SH_WR: begin
          ptr <= ptr - 1'b1;
          if ((ptr - 1'b1) > ins_pos) begin
            state <= S_SH_RD;
          end else begin
            state <= S_PLACE;
          end
        end
        S_PLACE: begin
          count <= count + 1'b1;
          state <= S_IDLE;
        end

        // delete: move entries down one place over the erased one
        S_DN_RD: begin
          state <= S_DN_WR;
        end
        S_DN_WR: begin
          ptr <= ptr + 1'b1;
          if (ptr_plus2 < (CNT_W + 1)'(count)) begin
            state <= S_DN_RD;
          end else begin
            count <= count - 1'b1;
            state <= S_IDLE;
          end
        end

        // range query: one result per entry, ascending
        S_RG_RD: begin
          state <= S_RG_OUT;
        end
        S_RG_OUT: begin
          ptr   <= ptr + 1'b1;
          n_res <= n_res + 1'b1;
          state <= range_last ? S_IDLE : S_RG_RD;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // table never holds more than its capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(ENTRIES))
    else $error("entry count above capacity");

  // error results are single and final
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    done && (result.status != ST_OK) |-> result.last)
    else $error("error result not marked last");

  // a non-final result means more are on the way
  a_more_pending: assert property (@(posedge clk) disable iff (rst)
    done && !result.last |-> busy)
    else $error("block idle with results still owed");

  // a known request always starts work
  a_take: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (request.operation <= OP_UPDATE) |=> busy)
    else $error("request taken but block not busy");

endmodule

FILE: bench/key_range_partition_table_core_tb.sv
`timescale 1ns / 1ps

module key_range_partition_table_core_tb;
  import krpt_pkg::*;

  localparam int ENTRIES = ENTRIES_DEF;
  localparam int KEY_BITS = KEY_BITS_DEF;
  localparam logic [KEY_W-1:0] KEY_TOP = {KEY_W{1'b1}} >> (KEY_W - KEY_BITS);
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;
  localparam int RANDOM_REQS = 104;
  localparam int QUIET_TAIL = 25;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t request = '0;
  logic done;
  rsp_t result;

  key_range_partition_table_core #(
    .ENTRIES (ENTRIES),
    .KEY_BITS(KEY_BITS)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .request(request),
    .done   (done),
    .result (result)
  );

  always #10 clk = ~clk;

  // mirror of the partition table, sorted by start key
  logic [KEY_W-1:0]  part_key  [ENTRIES];
  logic [ROOT_W-1:0] part_root [ENTRIES];
  int part_count = 0;

  req_t pending_reqs [$];   // requests still to be offered
  rsp_t table_replies [$];  // replies the table owes, oldest first

  // pools so that random requests hit keys and roots that exist
  logic [KEY_W-1:0]  key_pool  [$];
  logic [ROOT_W-1:0] root_pool [$];

  int requests_taken = 0;
  int ignored_reqs = 0;
  int results_checked = 0;
  int mismatch_count = 0;
  int peak_count = 0;
  int full_refusals = 0;
  int range_rows = 0;
  int longest_range = 0;
  int gap_left = 0;
  int stall_cycles = 0;
  rsp_t want;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // greatest start key not above k
  function automatic int floor_slot(logic [KEY_W-1:0] k);
    int f;
    int i;
    f = -1;
    for (i = 0; i < part_count; i++)
      if (part_key[i] <= k) f = i;
    return f;
  endfunction

  function automatic int exact_slot(logic [KEY_W-1:0] k);
    int i;
    for (i = 0; i < part_count; i++)
      if (part_key[i] == k) return i;
    return -1;
  endfunction

  // applies one taken request to the mirror and queues the replies it owes
  function automatic void apply_to_table(req_t r);
    rsp_t rs;
    logic [KEY_W-1:0] k;
    logic [KEY_W-1:0] kh;
    int f;
    int g;
    int n;
    int idx;
    int keep;
    int gone;
    k = r.key & KEY_TOP;
    kh = r.key_high & KEY_TOP;
    rs = '0;
    rs.status = ST_OK;
    rs.last = 1'b1;
    case (r.operation)
      OP_INSERT: begin
        if (exact_slot(k) >= 0) begin
          rs.status = ST_EXISTS;
        end else if (part_count >= ENTRIES) begin
          rs.status = ST_FULL;
          full_refusals++;
        end else begin
          // open a gap above the new key and drop it in
          idx = part_count;
          while (idx > 0 && part_key[idx-1] > k) begin
            part_key[idx] = part_key[idx-1];
            part_root[idx] = part_root[idx-1];
            idx--;
          end
          part_key[idx] = k;
          part_root[idx] = r.root;
          part_count++;
          if (part_count > peak_count) peak_count = part_count;
        end
        table_replies = {table_replies, rs};
      end
      OP_DELETE: begin
        f = floor_slot(k);
        if (f < 0) begin
          rs.status = ST_NOT_FOUND;
        end else if (part_count <= 1) begin
          rs.status = ST_LAST;
        end else begin
          // merge into the lower neighbour, or absorb the higher one at the bottom
          keep = (f > 0) ? f - 1 : 0;
          gone = (f > 0) ? f : 1;
          rs.root_a = part_root[keep];
          rs.root_b = part_root[gone];
          rs.key_a = part_key[keep];
          rs.key_b = part_key[gone];
          for (idx = gone; idx + 1 < part_count; idx++) begin
            part_key[idx] = part_key[idx+1];
            part_root[idx] = part_root[idx+1];
          end
          part_count--;
        end
        table_replies = {table_replies, rs};
      end
      OP_LOOKUP: begin
        f = floor_slot(k);
        if (f < 0) begin
          rs.status = ST_NOT_FOUND;
        end else begin
          rs.root_a = part_root[f];
          rs.key_a = part_key[f];
        end
        table_replies = {table_replies, rs};
      end
      OP_RANGE: begin
        f = floor_slot(k);
        g = floor_slot(kh);
        if (kh < k) begin
          rs.status = ST_UNORDERED;
          table_replies = {table_replies, rs};
        end else if (f < 0 || g < 0) begin
          rs.status = ST_NOT_FOUND;
          table_replies = {table_replies, rs};
        end else begin
          // one reply per partition, ascending, capped
          n = 0;
          for (idx = f; idx <= g && n < MAX_RESULTS; idx++) begin
            rs = '0;
            rs.status = ST_OK;
            rs.root_a = part_root[idx];
            rs.key_a = part_key[idx];
            rs.last = (idx == g || n == MAX_RESULTS - 1);
            table_replies = {table_replies, rs};
            n++;
          end
          range_rows += n;
          if (n > longest_range) longest_range = n;
        end
      end
      OP_BOUNDS: begin
        // highest start key carrying that root
        f = -1;
        for (idx = 0; idx < part_count; idx++)
          if (part_root[idx] == r.root) f = idx;
        if (f < 0) begin
          rs.status = ST_NOT_FOUND;
        end else begin
          rs.root_a = part_root[f];
          rs.key_a = part_key[f];
          if (f + 1 < part_count) rs.key_b = part_key[f+1];
          else rs.upper_is_infinite = 1'b1;
        end
        table_replies = {table_replies, rs};
      end
      OP_UPDATE: begin
        f = exact_slot(k);
        if (f < 0) rs.status = ST_NOT_FOUND;
        else part_root[f] = r.root;
        table_replies = {table_replies, rs};
      end
      default: begin
        ignored_reqs++;
      end
    endcase
  endfunction

  function automatic void queue_request(logic [2:0] op, logic [KEY_W-1:0] k,
                                        logic [KEY_W-1:0] kh, logic [ROOT_W-1:0] rt);
    req_t r;
    r.operation = op;
    r.key = k;
    r.key_high = kh;
    r.root = rt;
    pending_reqs = {pending_reqs, r};
  endfunction

  function automatic logic [KEY_W-1:0] wide_random();
    return {$urandom, $urandom} & KEY_TOP;
  endfunction

  // mostly keys already seen, some neighbours of them, some anywhere
  function automatic logic [KEY_W-1:0] pick_key();
    int p;
    logic [KEY_W-1:0] k;
    p = $urandom_range(0, 99);
    if (key_pool.size() != 0)
      k = key_pool[$urandom_range(0, key_pool.size() - 1)];
    else
      k = wide_random();
    if (p < 45) return k;
    if (p < 55) return (k + 1) & KEY_TOP;
    if (p < 62) return (k - 1) & KEY_TOP;
    if (p < 77) return wide_random();
    if (p < 87) return KEY_W'($urandom_range(0, 31));
    if (p < 93) return '0;
    return KEY_TOP;
  endfunction

  function automatic logic [ROOT_W-1:0] pick_root();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55 && root_pool.size() != 0)
      return root_pool[$urandom_range(0, root_pool.size() - 1)];
    if (p < 65) return '0;
    if (p < 75) return '1;
    return $urandom;
  endfunction

  // request side: offers queued requests with random idle bursts
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        apply_to_table(request);
        requests_taken++;
      end
      // a request still waiting on busy stays where it is
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_reqs.size() == 0) begin
          start <= 1'b0;
        end else if (pending_reqs.size() > QUIET_TAIL && $urandom_range(0, 3) == 0) begin
          gap_left = $urandom_range(0, 9);
          start <= 1'b0;
        end else begin
          request <= pending_reqs.pop_front();
          start <= 1'b1;
        end
      end
    end
  end

  // result side: every strobe is matched against the oldest owed reply
  always @(posedge clk) begin
    if (!rst && done) begin
      results_checked++;
      if (table_replies.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing owed, status %0d",
                                  results_checked, result.status));
      end else begin
        want = table_replies.pop_front();
        if (result.status !== want.status)
          report_mismatch($sformatf("result %0d status got %0d want %0d",
                                    results_checked, result.status, want.status));
        if (result.root_a !== want.root_a)
          report_mismatch($sformatf("result %0d root_a got %h want %h",
                                    results_checked, result.root_a, want.root_a));
        if (result.root_b !== want.root_b)
          report_mismatch($sformatf("result %0d root_b got %h want %h",
                                    results_checked, result.root_b, want.root_b));
        if (result.key_a !== want.key_a)
          report_mismatch($sformatf("result %0d key_a got %h want %h",
                                    results_checked, result.key_a, want.key_a));
        if (result.key_b !== want.key_b)
          report_mismatch($sformatf("result %0d key_b got %h want %h",
                                    results_checked, result.key_b, want.key_b));
        if (result.upper_is_infinite !== want.upper_is_infinite)
          report_mismatch($sformatf("result %0d upper_is_infinite got %b want %b",
                                    results_checked, result.upper_is_infinite,
                                    want.upper_is_infinite));
        if (result.last !== want.last)
          report_mismatch($sformatf("result %0d last got %b want %b",
                                    results_checked, result.last, want.last));
      end
    end
  end

  // watchdog: too long with neither a request taken nor a result shown
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int real_made;
    int phase;
    int p;
    int j;
    logic [2:0] op;
    logic [KEY_W-1:0] k;
    logic [KEY_W-1:0] kh;
    logic [KEY_W-1:0] swap;
    logic [ROOT_W-1:0] rt;
    logic [2:0] op_order [7];
    int op_cut [3][7];

    op_order = '{OP_INSERT, OP_DELETE, OP_LOOKUP, OP_RANGE, OP_BOUNDS, OP_UPDATE,
                 OP_SPARE_A};
    // cumulative weights: growing the table, mixed traffic, shrinking it
    op_cut = '{'{80, 82, 87, 92, 95, 98, 100},
               '{20, 35, 52, 72, 84, 96, 100},
               '{10, 50, 65, 80, 88, 96, 100}};

    // empty table: everything misses
    queue_request(OP_LOOKUP, '0, KEY_TOP, '0);
    queue_request(OP_DELETE, KEY_TOP, '0, '1);
    queue_request(OP_RANGE, '0, KEY_TOP, '0);
    queue_request(OP_BOUNDS, KEY_TOP, KEY_TOP, '1);
    queue_request(OP_UPDATE, '0, '0, 32'h1234_5678);
    // single partition: duplicate insert and refusal to drop the only entry
    queue_request(OP_INSERT, '0, KEY_TOP, '1);
    queue_request(OP_INSERT, '0, '0, 32'h0000_0001);
    queue_request(OP_DELETE, KEY_TOP, '0, '0);
    // extremes of the key space
    queue_request(OP_INSERT, KEY_TOP, '0, '0);
    queue_request(OP_INSERT, {1'b1, {(KEY_W-1){1'b0}}} & KEY_TOP, '0, 32'hA5A5_A5A5);
    queue_request(OP_RANGE, KEY_TOP, '0, '0);
    queue_request(OP_RANGE, '0, KEY_TOP, '0);
    queue_request(OP_RANGE, {1'b1, {(KEY_W-1){1'b0}}} & KEY_TOP,
                  {1'b1, {(KEY_W-1){1'b0}}} & KEY_TOP, '0);
    queue_request(OP_BOUNDS, '0, '0, '1);
    queue_request(OP_BOUNDS, '0, '0, '0);
    queue_request(OP_UPDATE, KEY_TOP, '0, 32'h5A5A_5A5A);
    queue_request(OP_LOOKUP, KEY_TOP - 1, '0, '0);
    // shared root: bounds picks the highest start key carrying it
    queue_request(OP_INSERT, KEY_W'(1), '0, 32'hA5A5_A5A5);
    queue_request(OP_BOUNDS, '0, '0, 32'hA5A5_A5A5);
    // lowest partition absorbs its higher neighbour, then an ordinary merge down
    queue_request(OP_DELETE, '0, '0, '0);
    queue_request(OP_DELETE, KEY_TOP - 1, '0, '0);
    // unknown codes and an update on a key that is not a start key
    queue_request(OP_SPARE_A, wide_random(), wide_random(), $urandom);
    queue_request(OP_SPARE_B, wide_random(), wide_random(), $urandom);
    queue_request(OP_UPDATE, KEY_W'(5), '0, '0);

    key_pool = {key_pool, KEY_W'(0)};
    key_pool = {key_pool, KEY_TOP};
    key_pool = {key_pool, {1'b1, {(KEY_W-1){1'b0}}} & KEY_TOP};
    root_pool = {root_pool, 32'hA5A5_A5A5};
    root_pool = {root_pool, 32'h5A5A_5A5A};

    real_made = 0;
    while (real_made < RANDOM_REQS) begin
      phase = (real_made < 36) ? 0 : (real_made < 80) ? 1 : 2;
      p = $urandom_range(0, 99);
      j = 0;
      while (p >= op_cut[phase][j]) j++;
      op = op_order[j];
      k = wide_random();
      kh = wide_random();
      rt = $urandom;
      case (op)
        OP_INSERT: begin
          p = $urandom_range(0, 99);
          if (p < 70) k = wide_random();
          else if (p < 85) k = KEY_W'($urandom_range(0, 63));
          else k = pick_key();
          rt = pick_root();
          key_pool = {key_pool, k};
          root_pool = {root_pool, rt};
        end
        OP_DELETE, OP_LOOKUP: k = pick_key();
        OP_RANGE: begin
          if ($urandom_range(0, 9) == 0) begin
            // full span: as many rows as the table holds
            k = '0;
            kh = KEY_TOP;
          end else begin
            k = pick_key();
            kh = pick_key();
            if (kh < k && $urandom_range(0, 4) != 0) begin
              swap = k;
              k = kh;
              kh = swap;
            end
          end
        end
        OP_BOUNDS: rt = pick_root();
        OP_UPDATE: begin
          k = pick_key();
          root_pool = {root_pool, rt};
        end
        default: op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
      endcase
      queue_request(op, k, kh, rt);
      if (op != OP_SPARE_A && op != OP_SPARE_B) real_made++;
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || start) @(posedge clk);
    while (table_replies.size() != 0) @(posedge clk);
    // room for a stray result after the last reply
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests taken (%0d with unused codes), %0d results checked",
             requests_taken, ignored_reqs, results_checked);
    $display("table peaked at %0d partitions, %0d full refusals, %0d range rows, longest %0d",
             peak_count, full_refusals, range_rows, longest_range);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: key_range_partition_table_core.f
src/krpt_pkg.sv
src/key_range_partition_table_core.sv
bench/key_range_partition_table_core_tb.sv
